FILE: design/assert_macros.svh
// Assertion helpers for the RTL, included by jox_scan.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, with no reset muting.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/jox_pkg.sv
// ----------------------------------------------------------------------------
// jox_pkg
// Types and constants for the JSON object extractor.
// ----------------------------------------------------------------------------
package jox_pkg;

   localparam int unsigned MAX_DEPTH = 255;
   localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int unsigned CHAR_W    = 8;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [DEPTH_W-1:0] depth_type;

   localparam depth_type DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
   localparam depth_type DEPTH_ONE = DEPTH_W'(1);

   localparam char_type CH_OPEN   = 8'h7B;
   localparam char_type CH_CLOSE  = 8'h7D;
   localparam char_type CH_QUOTE  = 8'h22;
   localparam char_type CH_BSLASH = 8'h5C;

   typedef enum logic [2:0] {
      ST_PENDING = 3'd0,
      ST_CLOSED  = 3'd1,
      ST_NONE    = 3'd2,
      ST_UNBAL   = 3'd3,
      ST_OVER    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_SEEK = 4'b0001,
      PH_SCAN = 4'b0010,
      PH_DONE = 4'b0100,
      PH_OVER = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       keep;
      status_type status;
   } result_type;

endpackage

FILE: design/json_object_extractor.sv
// ----------------------------------------------------------------------------
// json_object_extractor
// Picks the first complete top-level {...} object out of a byte stream.
// ----------------------------------------------------------------------------
// One byte per clock cycle sustained while rsp_stall is low. A byte is
// captured in the input register; when the output register is free, the
// brace depth, string and escape tracker updates and writes the result
// register. That tracker update is the loop that sets the rate. The
// end-of-text byte returns the tracker to its reset state, so the next byte
// starts a new text. No clearing pass after reset.

module json_object_extractor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jox_pkg::char_type req_char_in,
   input  logic              req_end_of_text,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jox_pkg::char_type rsp_byte_out,
   output logic              rsp_keep,
   output logic [2:0]        rsp_status,
   output logic              rsp_last_out
);
   import jox_pkg::*;

   logic       in_vld_ff;
   char_type   in_char_ff;
   logic       in_eot_ff;
   logic       out_vld_ff;
   char_type   out_char_ff;
   logic       out_keep_ff;
   status_type out_status_ff;
   logic       out_last_ff;
   logic       out_free, xfer, in_free;
   result_type res;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign xfer      = in_vld_ff && out_free;
   assign in_free   = !in_vld_ff || xfer;
   assign req_stall = !in_free;

   jox_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (xfer),
      .char_in     (in_char_ff),
      .end_of_text (in_eot_ff),
      .result      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_vld_ff <= req_valid;
         end
         if (out_free) begin
            out_vld_ff <= xfer;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_char_ff <= req_char_in;
         in_eot_ff  <= req_end_of_text;
      end
      if (xfer) begin
         out_char_ff   <= in_char_ff;
         out_keep_ff   <= res.keep;
         out_status_ff <= res.status;
         out_last_ff   <= in_eot_ff;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_byte_out = out_char_ff;
   assign rsp_keep     = out_keep_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last_out = out_last_ff;

endmodule

FILE: design/jox_scan.sv
// ----------------------------------------------------------------------------
// jox_scan
// Brace depth / string / escape tracker. Result is combinational from the
// current byte and state; state advances when step is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jox_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  jox_pkg::char_type  char_in,
   input  logic               end_of_text,
   output jox_pkg::result_type result
);
   import jox_pkg::*;

   phase_type phase_ff, phase_in;
   depth_type depth_ff, depth_in;
   logic      str_ff, str_in;
   logic      esc_ff, esc_in;
   depth_type depth_dec;
   logic      closed;

   always_comb begin
      phase_in      = phase_ff;
      depth_in      = depth_ff;
      str_in        = str_ff;
      esc_in        = esc_ff;
      result.keep   = 1'b0;
      result.status = ST_PENDING;
      closed        = 1'b0;
      depth_dec     = (depth_ff != '0) ? depth_ff - DEPTH_ONE : depth_ff;

      unique case (phase_ff)
         PH_SEEK: begin
            if (char_in == CH_OPEN) begin
               result.keep = 1'b1;
               depth_in    = DEPTH_ONE;
               str_in      = 1'b0;
               esc_in      = 1'b0;
               phase_in    = PH_SCAN;
               if (end_of_text) begin
                  result.status = ST_UNBAL;
               end
            end else if (end_of_text) begin
               result.status = ST_NONE;
            end
         end
         PH_SCAN: begin
            result.keep = 1'b1;
            priority if (str_ff) begin
               priority if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (char_in == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else if (char_in == CH_QUOTE) begin
                  str_in = 1'b0;
               end else begin
                  // ordinary string byte
               end
            end else if (char_in == CH_QUOTE) begin
               str_in = 1'b1;
            end else if (char_in == CH_OPEN) begin
               if (depth_ff >= DEPTH_MAX) begin
                  result.keep   = 1'b0;
                  result.status = ST_OVER;
                  phase_in      = PH_OVER;
               end else begin
                  depth_in = depth_ff + DEPTH_ONE;
               end
            end else if (char_in == CH_CLOSE) begin
               depth_in = depth_dec;
               if (depth_dec == '0) begin
                  result.status = ST_CLOSED;
                  closed        = 1'b1;
                  phase_in      = PH_DONE;
               end
            end else begin
               // any other byte outside a string leaves the tracker alone
            end
            if (end_of_text && !closed && phase_in == PH_SCAN) begin
               result.status = ST_UNBAL;
            end
         end
         PH_DONE: begin
         end
         PH_OVER: begin
            if (end_of_text) begin
               result.status = ST_OVER;
            end
         end
         default: begin
            phase_in = PH_SEEK;
         end
      endcase

      // end of text returns the tracker to its idle state
      if (end_of_text) begin
         phase_in = PH_SEEK;
         depth_in = '0;
         str_in   = 1'b0;
         esc_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         depth_ff <= '0;
         str_ff   <= 1'b0;
         esc_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         depth_ff <= depth_in;
         str_ff   <= str_in;
         esc_ff   <= esc_in;
      end
   end

   `ASSERT_CLK(a_scan_depth, clock, reset, (phase_ff == PH_SCAN) |-> (depth_ff != '0), "open object with zero depth")
   `ASSERT_CLK(a_idle_clear, clock, reset, (phase_ff == PH_SEEK || phase_ff == PH_DONE) |-> (depth_ff == '0 && !str_ff && !esc_ff), "idle phase with stale tracker state")
   `ASSERT_CLK(a_esc_in_str, clock, reset, esc_ff |-> str_ff, "escape pending outside a string")
   `ASSERT_CLK(a_keep_status, clock, reset, (step && result.keep) |-> (result.status != ST_NONE && result.status != ST_OVER), "kept byte with a no-object or overflow status")

endmodule

FILE: tb/sv/jox_checker.sv
// ----------------------------------------------------------------------------
// jox_checker
// Watches both channels of json_object_extractor. It tracks brace depth,
// string and escape state for every accepted request byte, queues the
// expected echo, and compares each response transaction field by field.
// ----------------------------------------------------------------------------
module jox_checker
   import jox_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  char_type   req_char_in,
   input  logic       req_end_of_text,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  char_type   rsp_byte_out,
   input  logic       rsp_keep,
   input  logic [2:0] rsp_status,
   input  logic       rsp_last_out,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      char_type   data;
      logic       keep;
      status_type status;
      logic       last;
   } echo_type;

   echo_type  echo_q[$];

   phase_type scan_phase;
   depth_type nest_depth;
   logic      str_open;
   logic      escape_next;

   function automatic void clear_tracker();
      scan_phase  = PH_SEEK;
      nest_depth  = '0;
      str_open    = 1'b0;
      escape_next = 1'b0;
   endfunction

   function automatic echo_type track_byte(input char_type c, input logic eot);
      echo_type   e;
      logic       keep;
      status_type st;
      logic       closed;
      keep   = 1'b0;
      st     = ST_PENDING;
      closed = 1'b0;
      case (scan_phase)
         PH_SEEK: begin
            if (c == CH_OPEN) begin
               keep        = 1'b1;
               nest_depth  = DEPTH_ONE;
               str_open    = 1'b0;
               escape_next = 1'b0;
               scan_phase  = PH_SCAN;
               if (eot) st = ST_UNBAL;
            end else if (eot) begin
               st = ST_NONE;
            end
         end
         PH_SCAN: begin
            keep = 1'b1;
            if (str_open) begin
               if (escape_next) escape_next = 1'b0;
               else if (c == CH_BSLASH) escape_next = 1'b1;
               else if (c == CH_QUOTE) str_open = 1'b0;
            end else if (c == CH_QUOTE) begin
               str_open = 1'b1;
            end else if (c == CH_OPEN) begin
               // one level too deep abandons the object
               if (nest_depth >= DEPTH_MAX) begin
                  keep       = 1'b0;
                  st         = ST_OVER;
                  scan_phase = PH_OVER;
               end else begin
                  nest_depth = nest_depth + DEPTH_ONE;
               end
            end else if (c == CH_CLOSE) begin
               if (nest_depth != '0) nest_depth = nest_depth - DEPTH_ONE;
               if (nest_depth == '0) begin
                  st         = ST_CLOSED;
                  closed     = 1'b1;
                  scan_phase = PH_DONE;
               end
            end
            if (eot && !closed && scan_phase == PH_SCAN) st = ST_UNBAL;
         end
         PH_DONE: ;
         default: begin
            if (eot) st = ST_OVER;
         end
      endcase
      e.data   = c;
      e.keep   = keep;
      e.status = st;
      e.last   = eot;
      if (eot) clear_tracker();
      return e;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      clear_tracker();
   end

   always @(posedge clock) begin
      echo_type want;
      if (reset) begin
         echo_q.delete();
         clear_tracker();
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            echo_q.push_back(track_byte(req_char_in, req_end_of_text));
         if (rsp_valid && !rsp_stall) begin
            if (echo_q.size() == 0) begin
               $error("unexpected rsp transaction: byte_out %0h", rsp_byte_out);
               fail_count++;
            end else begin
               want = echo_q.pop_front();
               if (rsp_byte_out !== want.data) begin
                  $error("byte_out: expected %0h, actual %0h", want.data, rsp_byte_out);
                  fail_count++;
               end
               if (rsp_keep !== want.keep) begin
                  $error("keep: expected %0b, actual %0b", want.keep, rsp_keep);
                  fail_count++;
               end
               if (rsp_status !== 3'(want.status)) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out: expected %0b, actual %0b", want.last, rsp_last_out);
                  fail_count++;
               end
            end
         end
         pending_count <= echo_q.size();
      end
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for json_object_extractor: directed texts for prefix skipping,
// strings, escapes, closing and truncation, then random texts with one depth-limit text,
// mostly well-formed objects with random content. Random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import jox_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_BUDGET = 750;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   char_type   req_char_in;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_stall;
   char_type   rsp_byte_out;
   logic       rsp_keep;
   logic [2:0] rsp_status;
   logic       rsp_last_out;
   int         fail_count;
   int         pending_count;

   logic       quiet;
   int         item_count;
   char_type   text_q[$];

   json_object_extractor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_keep        (rsp_keep),
      .rsp_status      (rsp_status),
      .rsp_last_out    (rsp_last_out)
   );

   jox_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_keep        (rsp_keep),
      .rsp_status      (rsp_status),
      .rsp_last_out    (rsp_last_out),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= !reset && !quiet && ($urandom_range(0, 99) < 13);
      end
   end

   initial begin
      #2_000_000;
      $display("json_object_extractor: mismatch");
      $finish;
   end

   // any byte that is not a brace or a quote
   function automatic char_type plain_byte();
      char_type c;
      do c = char_type'($urandom_range(0, 255));
      while (c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE);
      return c;
   endfunction

   task automatic send_byte(input char_type c, input logic eot);
      if (!quiet && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_in     <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
         item_count++;
      end
   endtask

   task automatic add_string();
      int n;
      n = $urandom_range(0, 6);
      text_q.push_back(CH_QUOTE);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: begin
               text_q.push_back(CH_BSLASH);
               text_q.push_back(char_type'($urandom_range(0, 255)));
            end
            1: text_q.push_back($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
            default: begin
               char_type c;
               do c = char_type'($urandom_range(0, 255));
               while (c == CH_QUOTE || c == CH_BSLASH);
               text_q.push_back(c);
            end
         endcase
      end
      text_q.push_back(CH_QUOTE);
   endtask

   // inner closes never reach depth 0, so only the final brace ends it
   task automatic add_object(input int max_nest);
      int d;
      int steps;
      d     = 1;
      steps = $urandom_range(0, 12);
      text_q.push_back(CH_OPEN);
      for (int n = 0; n < steps; n++) begin
         case ($urandom_range(0, 5))
            0: if (d < max_nest) begin
               text_q.push_back(CH_OPEN);
               d++;
            end else text_q.push_back(plain_byte());
            1: if (d > 1) begin
               text_q.push_back(CH_CLOSE);
               d--;
            end else text_q.push_back(plain_byte());
            2, 3: add_string();
            default: text_q.push_back(plain_byte());
         endcase
      end
      while (d > 0) begin
         text_q.push_back(CH_CLOSE);
         d--;
      end
   endtask

   task automatic add_noise(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) text_q.push_back(plain_byte());
   endtask

   // past the limit the object is dropped, so a few closes are enough
   task automatic add_deep(input int levels);
      repeat (levels) text_q.push_back(CH_OPEN);
      add_string();
      text_q.push_back(plain_byte());
      repeat ($urandom_range(1, 3)) text_q.push_back(CH_CLOSE);
   endtask

   initial begin
      int text_n;
      int cut;
      int kind;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_char_in     = '0;
      req_end_of_text = 1'b0;
      quiet           = 1'b0;
      item_count      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // prefix, braces and an escaped quote inside a string, close, then a dropped byte
      text_q = '{8'h78, 8'h00, 8'hFF, CH_OPEN, CH_QUOTE, CH_OPEN, CH_BSLASH, CH_QUOTE,
                 CH_CLOSE, CH_QUOTE, CH_CLOSE, 8'h7A};
      send_text();
      text_q = '{8'h71};                          // no object at all
      send_text();
      text_q = '{CH_OPEN};                        // text ends on the opening brace
      send_text();
      text_q = '{CH_OPEN, CH_CLOSE};              // close on the last byte
      send_text();
      text_q = '{CH_OPEN, CH_BSLASH, CH_CLOSE};   // backslash outside a string
      send_text();
      text_q = '{CH_OPEN, CH_QUOTE, 8'h61};       // ends open inside a string
      send_text();
      text_q = '{CH_CLOSE, CH_QUOTE, CH_OPEN, CH_CLOSE};
      send_text();

      text_n = 0;
      while (item_count < ITEM_BUDGET) begin
         text_q.delete();
         quiet = (item_count >= 300 && item_count < 450);
         if (text_n == 2) begin
            add_deep(MAX_DEPTH + 1);
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
               add_noise(0, 3);
               add_object($urandom_range(1, 5));
               add_noise(0, 3);
            end else if (kind < 77) begin
               add_noise(0, 2);
               add_object($urandom_range(1, 5));
               cut = $urandom_range(0, text_q.size() - 2);
               while (text_q.size() > cut + 1) void'(text_q.pop_back());
            end else if (kind < 84) begin
               add_noise(1, 6);
            end else if (kind < 92) begin
               repeat ($urandom_range(1, 4))
                  text_q.push_back($urandom_range(0, 1) ? CH_CLOSE : CH_QUOTE);
               add_object($urandom_range(1, 3));
               add_noise(0, 2);
            end else begin
               repeat ($urandom_range(1, 8))
                  text_q.push_back(char_type'($urandom_range(0, 255)));
            end
         end
         send_text();
         text_n++;
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      // let the checker register the last accepted byte before polling
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("json_object_extractor: match");
      end else begin
         $display("json_object_extractor: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/jox_pkg.sv
design/jox_scan.sv
design/json_object_extractor.sv
tb/sv/jox_checker.sv
tb/sv/tb.sv
